@@ design/lpd_pkg.sv @@
// Package: shared types and constants of the longest path depth unit.
package lpd_pkg;

  localparam int unsigned EDGE_W = 19;
  localparam int unsigned DEPTH_W = 16;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 16'd65534;

  typedef enum logic [1:0] {
    CMD_NODE = 2'd0,
    CMD_EDGE = 2'd1,
    CMD_RUN  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_EDGE_RD,
    S_EDGE_CHK,
    S_SRC_CHK,
    S_DST_UPD,
    S_PASS_END,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic run_start;
    logic load_node;
    logic load_edge;
    logic clr_wr;
    logic pass_start;
    logic pass_inc;
    logic edge_rd;
    logic edge_chk;
    logic src_chk;
    logic dst_upd;
    logic scan_start;
    logic scan_rd;
    logic scan_chk;
    logic result_ld;
  } ctl_t;

  typedef struct packed {
    logic node_idx_end;
    logic edge_idx_end;
    logic edge_ok;
    logic src_attached;
    logic stop;
    logic out_free;
  } sts_t;

endpackage

@@ design/lpd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/lpd_datapath.sv @@
// Datapath: node/edge stores, depth memory, counters and result register.
module lpd_datapath import lpd_pkg::*; #(
  parameter int unsigned MAX_NODES = 256,
  parameter int unsigned MAX_EDGES = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctl_t                 ctl_i,
  output sts_t                 sts_o,
  input  logic                 is_attached_i,
  input  logic signed [8:0]    from_node_i,
  input  logic signed [8:0]    to_node_i,
  input  logic                 is_feedback_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DEPTH_W-1:0]   min_columns_o,
  output logic                 overflowed_o
);

  localparam int unsigned NIDX_W = $clog2(MAX_NODES);
  localparam int unsigned EIDX_W = $clog2(MAX_EDGES);
  localparam int unsigned NCNT_W = $clog2(MAX_NODES + 1);
  localparam int unsigned ECNT_W = $clog2(MAX_EDGES + 1);

  logic [NCNT_W-1:0]  node_count_q, node_idx_q, pass_q;
  logic [ECNT_W-1:0]  edge_count_q, edge_idx_q;
  logic               overflow_q, changed_q, sat_q;
  logic [NIDX_W-1:0]  dst_q;
  logic [DEPTH_W-1:0] cand_q, best_q;
  logic               out_valid_q, overflowed_q;
  logic [DEPTH_W-1:0] min_columns_q;

  logic               node_full, edge_full;
  logic [EDGE_W-1:0]  edge_wdata, edge_rdata;
  logic [8:0]         e_from, e_to;
  logic               e_fb, from_ok, to_ok;
  logic [NIDX_W-1:0]  src_idx, dst_idx, node_idx;
  logic               att_we, att_re, att_rdata;
  logic [NIDX_W-1:0]  att_raddr;
  logic               dep_we, dep_re;
  logic [NIDX_W-1:0]  dep_waddr, dep_raddr;
  logic [DEPTH_W-1:0] dep_wdata, dep_rdata;
  logic               dep_raise;

  assign node_full = (node_count_q == NCNT_W'(MAX_NODES));
  assign edge_full = (edge_count_q == ECNT_W'(MAX_EDGES));
  assign node_idx  = NIDX_W'(node_idx_q);

  assign edge_wdata = {is_feedback_i, to_node_i, from_node_i};
  assign e_from = edge_rdata[8:0];
  assign e_to   = edge_rdata[17:9];
  assign e_fb   = edge_rdata[18];
  assign from_ok = !e_from[8] && (32'(e_from[7:0]) < 32'(node_count_q));
  assign to_ok   = !e_to[8] && (32'(e_to[7:0]) < 32'(node_count_q));
  assign src_idx = NIDX_W'(e_from[7:0]);
  assign dst_idx = NIDX_W'(e_to[7:0]);

  lpd_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.load_edge && !edge_full),
    .waddr_i (EIDX_W'(edge_count_q)),
    .wdata_i (edge_wdata),
    .re_i    (ctl_i.edge_rd),
    .raddr_i (EIDX_W'(edge_idx_q)),
    .rdata_o (edge_rdata)
  );

  assign att_we    = ctl_i.load_node && !node_full;
  assign att_re    = ctl_i.edge_chk || ctl_i.scan_rd;
  assign att_raddr = ctl_i.scan_rd ? node_idx : src_idx;

  lpd_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_att_ram (
    .clk_i   (clk_i),
    .we_i    (att_we),
    .waddr_i (NIDX_W'(node_count_q)),
    .wdata_i (is_attached_i),
    .re_i    (att_re),
    .raddr_i (att_raddr),
    .rdata_o (att_rdata)
  );

  assign dep_raise = (dep_rdata < cand_q);

  always_comb begin
    dep_re    = ctl_i.edge_chk || ctl_i.src_chk || ctl_i.scan_rd;
    dep_raddr = src_idx;
    if (ctl_i.scan_rd) begin
      dep_raddr = node_idx;
    end else if (ctl_i.src_chk) begin
      dep_raddr = dst_q;
    end
    dep_we    = ctl_i.clr_wr || (ctl_i.dst_upd && dep_raise);
    dep_waddr = ctl_i.clr_wr ? node_idx : dst_q;
    dep_wdata = ctl_i.clr_wr ? '0 : cand_q;
  end

  lpd_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_NODES)) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (dep_we),
    .waddr_i (dep_waddr),
    .wdata_i (dep_wdata),
    .re_i    (dep_re),
    .raddr_i (dep_raddr),
    .rdata_o (dep_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= '0;
      edge_count_q <= '0;
      overflow_q   <= 1'b0;
      node_idx_q   <= '0;
      edge_idx_q   <= '0;
      pass_q       <= '0;
      changed_q    <= 1'b0;
      sat_q        <= 1'b0;
      best_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (ctl_i.load_node) begin
        if (node_full) begin
          overflow_q <= 1'b1;
        end else begin
          node_count_q <= node_count_q + NCNT_W'(1);
        end
      end
      if (ctl_i.load_edge) begin
        if (edge_full) begin
          overflow_q <= 1'b1;
        end else begin
          edge_count_q <= edge_count_q + ECNT_W'(1);
        end
      end
      if (ctl_i.run_start) begin
        node_idx_q <= '0;
        pass_q     <= '0;
        sat_q      <= 1'b0;
        best_q     <= '0;
      end
      if (ctl_i.clr_wr || ctl_i.scan_chk) begin
        node_idx_q <= node_idx_q + NCNT_W'(1);
      end
      if (ctl_i.scan_start) begin
        node_idx_q <= '0;
      end
      if (ctl_i.pass_start || ctl_i.pass_inc) begin
        edge_idx_q <= '0;
        changed_q  <= 1'b0;
      end
      if (ctl_i.pass_inc) begin
        pass_q <= pass_q + NCNT_W'(1);
      end
      if (ctl_i.edge_chk) begin
        edge_idx_q <= edge_idx_q + ECNT_W'(1);
      end
      if (ctl_i.src_chk && (dep_rdata == DEPTH_MAX)) begin
        sat_q <= 1'b1;
      end
      if (ctl_i.dst_upd && dep_raise) begin
        changed_q <= 1'b1;
      end
      if (ctl_i.scan_chk && !att_rdata && (dep_rdata > best_q)) begin
        best_q <= dep_rdata;
      end
      if (ctl_i.result_ld) begin
        out_valid_q  <= 1'b1;
        node_count_q <= '0;
        edge_count_q <= '0;
        overflow_q   <= 1'b0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.edge_chk) begin
      dst_q <= dst_idx;
    end
    if (ctl_i.src_chk) begin
      cand_q <= (dep_rdata == DEPTH_MAX) ? DEPTH_MAX : dep_rdata + DEPTH_W'(1);
    end
    if (ctl_i.result_ld) begin
      min_columns_q <= best_q + DEPTH_W'(1);
      overflowed_q  <= overflow_q || sat_q;
    end
  end

  always_comb begin
    sts_o.node_idx_end = (node_idx_q == node_count_q);
    sts_o.edge_idx_end = (edge_idx_q == edge_count_q);
    sts_o.edge_ok      = from_ok && to_ok && !e_fb;
    sts_o.src_attached = att_rdata;
    sts_o.stop         = !changed_q || (pass_q == node_count_q);
    sts_o.out_free     = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o   = out_valid_q;
  assign min_columns_o = min_columns_q;
  assign overflowed_o  = overflowed_q;

endmodule

@@ design/lpd_ctrl.sv @@
// Controller: state machine sequencing loads, clear, relaxation passes and scan.
module lpd_ctrl import lpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  sts_t       sts_i,
  output ctl_t       ctl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (cmd_e'(command_i))
            CMD_NODE: ctl_o.load_node = 1'b1;
            CMD_EDGE: ctl_o.load_edge = 1'b1;
            CMD_RUN: begin
              ctl_o.run_start = 1'b1;
              state_d = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        if (sts_i.node_idx_end) begin
          ctl_o.pass_start = 1'b1;
          state_d = S_EDGE_RD;
        end else begin
          ctl_o.clr_wr = 1'b1;
        end
      end
      S_EDGE_RD: begin
        if (sts_i.edge_idx_end) begin
          state_d = S_PASS_END;
        end else begin
          ctl_o.edge_rd = 1'b1;
          state_d = S_EDGE_CHK;
        end
      end
      S_EDGE_CHK: begin
        ctl_o.edge_chk = 1'b1;
        state_d = sts_i.edge_ok ? S_SRC_CHK : S_EDGE_RD;
      end
      S_SRC_CHK: begin
        if (sts_i.src_attached) begin
          state_d = S_EDGE_RD;
        end else begin
          ctl_o.src_chk = 1'b1;
          state_d = S_DST_UPD;
        end
      end
      S_DST_UPD: begin
        ctl_o.dst_upd = 1'b1;
        state_d = S_EDGE_RD;
      end
      S_PASS_END: begin
        if (sts_i.stop) begin
          ctl_o.scan_start = 1'b1;
          state_d = S_SCAN_RD;
        end else begin
          ctl_o.pass_inc = 1'b1;
          state_d = S_EDGE_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts_i.node_idx_end) begin
          state_d = S_DONE;
        end else begin
          ctl_o.scan_rd = 1'b1;
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        ctl_o.scan_chk = 1'b1;
        state_d = S_SCAN_RD;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.result_ld = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

@@ design/longest_path_depth_unit.sv @@
// Top level: longest path depth unit, controller plus datapath.
//
//   channel  dir  handshake             payload
//   input    in   in_valid_i/in_stall_o command_i, is_attached_i, from_node_i,
//                                       to_node_i, is_feedback_i
//   output   out  out_valid_o/out_stall_i min_columns_o, overflowed_o
//
// Node and edge loads are accepted back to back while the unit is idle.
// A run makes relaxation passes over the edges, walking them through single-read-port
// memories, and then scans the nodes for the result.
// The depth memory is cleared, one node at a time, at the start of each run.
// in_stall_o is high from run transfer until the result is loaded.
// Reset clears counts, overflow mark and output valid; stores hold no reset.
module longest_path_depth_unit import lpd_pkg::*; #(
  parameter int unsigned MAX_NODES = 256,
  parameter int unsigned MAX_EDGES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic               is_attached_i,
  input  logic signed [8:0]  from_node_i,
  input  logic signed [8:0]  to_node_i,
  input  logic               is_feedback_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        min_columns_o,
  output logic               overflowed_o
);

  ctl_t ctl;
  sts_t sts;

  lpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  lpd_datapath #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .is_attached_i (is_attached_i),
    .from_node_i   (from_node_i),
    .to_node_i     (to_node_i),
    .is_feedback_i (is_feedback_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .min_columns_o (min_columns_o),
    .overflowed_o  (overflowed_o)
  );

  a_load_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.load_node || ctl.load_edge || ctl.run_start) |-> (in_valid_i && !in_stall_o))
    else $error("load issued without input transfer");

  a_result_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.result_ld |=> (out_valid_o && !in_stall_o))
    else $error("result load did not raise output valid");

  a_depth_write_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl.clr_wr, ctl.dst_upd, ctl.src_chk, ctl.edge_chk, ctl.scan_chk,
              ctl.result_ld}))
    else $error("conflicting datapath steps");

  a_result_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.result_ld |-> (!out_valid_o || !out_stall_i))
    else $error("result overwrote a pending output");

endmodule
